FILE: rtl/core/prba_pkg.sv
// shared types and constants for the page region bump allocator
`timescale 1ns / 1ps
`default_nettype none

package prba_pkg;

   localparam int BASE_W     = 48;
   localparam int PAGE_W     = 36;
   localparam int PAGES_W    = 37;
   localparam int STATUS_W   = 3;
   localparam int MODE_W     = 2;
   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 128;

   localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK         = 3'd0,
      STATUS_ZERO       = 3'd1,
      STATUS_FULL       = 3'd2,
      STATUS_MISALIGNED = 3'd3,
      STATUS_PAST_END   = 3'd4,
      STATUS_OVERLAP    = 3'd5,
      STATUS_NO_ROOM    = 3'd6
   } status_type;

   typedef struct packed {
      logic [BASE_W-1:0] base;
      logic [PAGE_W-1:0] size;
      logic [PAGE_W-1:0] used;
   } entry_type;

   // operands of the shared adder: a + (b << page shift when scaled)
   typedef struct packed {
      logic [BASE_W-1:0] a;
      logic [PAGE_W-1:0] b;
      logic              scaled;
   } unit_op_type;

endpackage

`default_nettype wire

FILE: rtl/core/page_region_bump_allocator.sv
// top level: first-fit page allocator over a table of bump-allocated regions
// clear, unused mode and accept-time rejects go from accept straight to the result state
// add region: end check, then scan of stored regions up to any overlap; no scan if empty or past end
// allocate: scan in table order to the first entry with room, bump its used mark, form the address
// throughput: one request at a time; the next word is taken the cycle after the result is taken
// reset (synchronous, active high) empties the table and zeroes both page counters, no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module page_region_bump_allocator import prba_pkg::*; #(
   parameter int MAX_REGIONS     = 128,
   parameter int PAGE_BYTES_LOG2 = 12,
   parameter int ADDR_BITS       = 48
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // region_base [47:0], req_pages [83:48], zero fill [87:84]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // mode [1:0]
   input  wire logic [MODE_W-1:0]     req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // alloc_address [47:0], total_pages [84:48], free_count [121:85], zero fill [127:122]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // status [2:0]
   output logic [STATUS_W-1:0]        rsp_tuser
);

   localparam int IDX_W    = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int CNT_W    = $clog2(MAX_REGIONS + 1);
   localparam int SCALED_W = PAGE_W + PAGE_BYTES_LOG2;
   // widest region end: base plus scaled page count, one carry bit
   localparam int SUM_W    = ((SCALED_W > BASE_W) ? SCALED_W : BASE_W) + 1;
   localparam int CMP_W    = (ADDR_BITS + 1 > SUM_W) ? ADDR_BITS + 1 : SUM_W;
   localparam logic [CMP_W-1:0] LIMIT = CMP_W'(1) << ADDR_BITS;

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_ENDCALC  = 8'b0000_0010,
      S_ENDCHK   = 8'b0000_0100,
      S_SCAN     = 8'b0000_1000,
      S_ADDR     = 8'b0001_0000,
      S_ADDRDONE = 8'b0010_0000,
      S_COMMIT   = 8'b0100_0000,
      S_RESP     = 8'b1000_0000
   } state_type;

   // control
   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [PAGES_W-1:0]  total_ff, total_in;
   logic [PAGES_W-1:0]  free_ff, free_in;
   logic [CNT_W-1:0]    issue_ff, issue_in;
   logic                rd_valid_ff, rd_valid_in;
   logic                s2_valid_ff, s2_valid_in;

   // request and result payload
   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic [BASE_W-1:0]   base_ff, base_in;
   logic [PAGE_W-1:0]   want_ff, want_in;
   logic [SUM_W-1:0]    end_ff, end_in;
   status_type          status_ff, status_in;
   logic [BASE_W-1:0]   addr_ff, addr_in;

   // scan pipeline and winning entry
   logic [IDX_W-1:0]    rd_idx_ff, rd_idx_in;
   entry_type           rd_data_ff;
   logic [IDX_W-1:0]    s2_idx_ff, s2_idx_in;
   entry_type           s2_entry_ff, s2_entry_in;
   logic [IDX_W-1:0]    win_idx_ff, win_idx_in;
   entry_type           win_entry_ff, win_entry_in;
   logic [PAGE_W-1:0]   new_used_ff, new_used_in;

   // region table
   entry_type           entry_mem_ff [MAX_REGIONS];
   logic                mem_we;
   logic [IDX_W-1:0]    mem_waddr;
   entry_type           mem_wdata;

   unit_op_type         unit_op;
   logic [SUM_W-1:0]    unit_sum;

   logic                hit;
   logic                last;
   logic                scan_stop;

   function automatic logic [PAGES_W-1:0] sat_add(input logic [PAGES_W-1:0] acc,
                                                  input logic [PAGE_W-1:0]  pages);
      logic [PAGES_W:0] s;
      s = {1'b0, acc} + (PAGES_W + 1)'(pages);
      return s[PAGES_W] ? {PAGES_W{1'b1}} : s[PAGES_W-1:0];
   endfunction

   prba_sum_unit #(
      .SHIFT (PAGE_BYTES_LOG2),
      .SUM_W (SUM_W)
   ) u_sum (
      .clock (clock),
      .op    (unit_op),
      .sum   (unit_sum)
   );

   // stage 2 decision: the unit sum lines up with the stage 2 entry
   always_comb begin
      if (mode_ff == MODE_ADD) begin
         // new region [base, end) against stored [eb, ee), ee in the unit sum
         hit = (end_ff > SUM_W'(s2_entry_ff.base)) && (SUM_W'(base_ff) < unit_sum);
      end else begin
         // used + want is at most size
         hit = unit_sum <= SUM_W'(s2_entry_ff.size);
      end
      last      = (CNT_W'(s2_idx_ff) + CNT_W'(1)) == count_ff;
      scan_stop = s2_valid_ff && (hit || last);
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      free_in      = free_ff;
      issue_in     = issue_ff;
      rd_valid_in  = 1'b0;
      s2_valid_in  = 1'b0;
      mode_in      = mode_ff;
      base_in      = base_ff;
      want_in      = want_ff;
      end_in       = end_ff;
      status_in    = status_ff;
      addr_in      = addr_ff;
      rd_idx_in    = issue_ff[IDX_W-1:0];
      s2_idx_in    = rd_idx_ff;
      s2_entry_in  = rd_data_ff;
      win_idx_in   = win_idx_ff;
      win_entry_in = win_entry_ff;
      new_used_in  = new_used_ff;
      mem_we       = 1'b0;
      mem_waddr    = count_ff[IDX_W-1:0];
      mem_wdata    = '{base: base_ff, size: want_ff, used: '0};

      // scan operands by default: stored end for add, used + want for allocate
      if (mode_ff == MODE_ADD) begin
         unit_op = '{a: rd_data_ff.base, b: rd_data_ff.size, scaled: 1'b1};
      end else begin
         unit_op = '{a: BASE_W'(rd_data_ff.used), b: want_ff, scaled: 1'b0};
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               mode_in   = req_tuser;
               base_in   = req_tdata[BASE_W-1:0];
               want_in   = req_tdata[BASE_W+PAGE_W-1:BASE_W];
               addr_in   = '0;
               status_in = STATUS_OK;
               issue_in  = '0;
               state_in  = S_RESP;
               unique case (req_tuser)
                  MODE_ADD: begin
                     if (req_tdata[BASE_W+PAGE_W-1:BASE_W] == '0) begin
                        status_in = STATUS_ZERO;
                     end else if (count_ff >= CNT_W'(MAX_REGIONS)) begin
                        status_in = STATUS_FULL;
                     end else if (req_tdata[PAGE_BYTES_LOG2-1:0] != '0) begin
                        status_in = STATUS_MISALIGNED;
                     end else begin
                        state_in = S_ENDCALC;
                     end
                  end
                  MODE_ALLOC: begin
                     if (req_tdata[BASE_W+PAGE_W-1:BASE_W] == '0) begin
                        status_in = STATUS_ZERO;
                     end else if (count_ff == '0) begin
                        status_in = STATUS_NO_ROOM;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  MODE_CLEAR: begin
                     count_in = '0;
                     total_in = '0;
                     free_in  = '0;
                  end
                  default: begin
                     // unused mode: plain ok, nothing changes
                  end
               endcase
            end
         end
         S_ENDCALC: begin
            unit_op  = '{a: base_ff, b: want_ff, scaled: 1'b1};
            state_in = S_ENDCHK;
         end
         S_ENDCHK: begin
            end_in = unit_sum;
            if (CMP_W'(unit_sum) > LIMIT) begin
               status_in = STATUS_PAST_END;
               state_in  = S_RESP;
            end else if (count_ff == '0) begin
               state_in = S_COMMIT;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            rd_valid_in = (issue_ff < count_ff) && !scan_stop;
            if (rd_valid_in) begin
               issue_in = issue_ff + CNT_W'(1);
            end
            s2_valid_in = rd_valid_ff && !scan_stop;
            if (s2_valid_ff) begin
               if (hit) begin
                  if (mode_ff == MODE_ADD) begin
                     status_in = STATUS_OVERLAP;
                     state_in  = S_RESP;
                  end else begin
                     win_idx_in   = s2_idx_ff;
                     win_entry_in = s2_entry_ff;
                     new_used_in  = unit_sum[PAGE_W-1:0];
                     state_in     = S_ADDR;
                  end
               end else if (last) begin
                  if (mode_ff == MODE_ADD) begin
                     state_in = S_COMMIT;
                  end else begin
                     status_in = STATUS_NO_ROOM;
                     state_in  = S_RESP;
                  end
               end
            end
         end
         S_ADDR: begin
            unit_op   = '{a: win_entry_ff.base, b: win_entry_ff.used, scaled: 1'b1};
            mem_we    = 1'b1;
            mem_waddr = win_idx_ff;
            mem_wdata = '{base: win_entry_ff.base, size: win_entry_ff.size, used: new_used_ff};
            free_in   = (free_ff > PAGES_W'(want_ff)) ? free_ff - PAGES_W'(want_ff) : '0;
            state_in  = S_ADDRDONE;
         end
         S_ADDRDONE: begin
            addr_in  = unit_sum[BASE_W-1:0];
            state_in = S_RESP;
         end
         S_COMMIT: begin
            mem_we   = 1'b1;
            count_in = count_ff + CNT_W'(1);
            total_in = sat_add(total_ff, want_ff);
            free_in  = sat_add(free_ff, want_ff);
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         count_ff    <= '0;
         total_ff    <= '0;
         free_ff     <= '0;
         issue_ff    <= '0;
         rd_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         total_ff    <= total_in;
         free_ff     <= free_in;
         issue_ff    <= issue_in;
         rd_valid_ff <= rd_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      base_ff      <= base_in;
      want_ff      <= want_in;
      end_ff       <= end_in;
      status_ff    <= status_in;
      addr_ff      <= addr_in;
      rd_idx_ff    <= rd_idx_in;
      s2_idx_ff    <= s2_idx_in;
      s2_entry_ff  <= s2_entry_in;
      win_idx_ff   <= win_idx_in;
      win_entry_ff <= win_entry_in;
      new_used_ff  <= new_used_in;
   end

   // region table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem_ff[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= entry_mem_ff[issue_ff[IDX_W-1:0]];
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RESP);
   assign rsp_tdata  = RSP_DATA_W'({free_ff, total_ff, addr_ff});
   assign rsp_tuser  = status_ff;

endmodule

`default_nettype wire

FILE: rtl/core/prba_sum_unit.sv
// shared registered adder used for region ends, fit tests and addresses
`timescale 1ns / 1ps
`default_nettype none

module prba_sum_unit import prba_pkg::*; #(
   parameter int SHIFT = 12,
   parameter int SUM_W = 58
) (
   input  wire logic             clock,
   input  wire unit_op_type      op,
   output logic     [SUM_W-1:0]  sum
);

   logic [SUM_W-1:0] sum_ff;
   logic [SUM_W-1:0] sum_in;
   logic [SUM_W-1:0] addend;

   always_comb begin
      addend = op.scaled ? (SUM_W'(op.b) << SHIFT) : SUM_W'(op.b);
      sum_in = SUM_W'(op.a) + addend;
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   assign sum = sum_ff;

endmodule

`default_nettype wire

FILE: rtl/core/prba_checker.sv
// port-level checks for the page region bump allocator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module prba_port_checks import prba_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [STATUS_W-1:0]   rsp_tuser
);

   // a pending result word stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result word dropped while stalled");

   // one request at a time: nothing accepted while a result waits
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request accepted while result pending");

   // reset leaves the block idle and ready
   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("not idle after reset");

   // a nonzero address only comes with an ok status
   a_addr_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[BASE_W-1:0] != '0) |-> rsp_tuser == STATUS_OK)
      else $error("address returned with failing status");

   // free pages never exceed the stored total
   a_free_le_total: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[BASE_W+2*PAGES_W-1:BASE_W+PAGES_W]
                     <= rsp_tdata[BASE_W+PAGES_W-1:BASE_W])
      else $error("free pages above total pages");

endmodule

bind page_region_bump_allocator prba_port_checks u_prba_port_checks (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

FILE: tb/prba_checker.sv
`timescale 1ns / 1ps
// result checker for the page region bump allocator, with its own region table and counters
module prba_checker import prba_pkg::*; #(
   parameter int MAX_REGIONS     = 128,
   parameter int PAGE_BYTES_LOG2 = 12,
   parameter int ADDR_BITS       = 48
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [MODE_W-1:0]     req_tuser,
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic [STATUS_W-1:0]   rsp_tuser,
   output int                         mismatches,
   output int                         outstanding
);

   typedef struct packed {
      logic [BASE_W-1:0]  address;
      status_type         status;
      logic [PAGES_W-1:0] total;
      logic [PAGES_W-1:0] pages_left;
   } outcome_type;

   localparam logic [PAGES_W-1:0] PAGES_MAX = '1;

   logic [BASE_W-1:0]  tbl_base [MAX_REGIONS];
   logic [PAGE_W-1:0]  tbl_size [MAX_REGIONS];
   logic [PAGE_W-1:0]  tbl_used [MAX_REGIONS];
   int                 tbl_count;
   logic [PAGES_W-1:0] sum_total;
   logic [PAGES_W-1:0] sum_free;
   outcome_type        awaited_q [$];
   int                 err_count;

   function automatic logic [PAGES_W-1:0] sat_sum(input logic [PAGES_W-1:0] a,
                                                  input logic [PAGE_W-1:0] b);
      logic [PAGES_W:0] s;
      s = {1'b0, a} + {2'b0, b};
      return (s > {1'b0, PAGES_MAX}) ? PAGES_MAX : s[PAGES_W-1:0];
   endfunction

   function automatic logic [63:0] end_of(input logic [BASE_W-1:0] b,
                                          input logic [PAGE_W-1:0] n);
      return 64'(b) + (64'(n) << PAGE_BYTES_LOG2);
   endfunction

   function automatic status_type try_add(input logic [BASE_W-1:0] base,
                                          input logic [PAGE_W-1:0] pages);
      logic [63:0] stop;
      int          i;
      if (pages == '0) return STATUS_ZERO;
      if (tbl_count >= MAX_REGIONS) return STATUS_FULL;
      if (base[PAGE_BYTES_LOG2-1:0] != '0) return STATUS_MISALIGNED;
      stop = end_of(base, pages);
      if (ADDR_BITS < 64 && stop > (64'd1 << ADDR_BITS)) return STATUS_PAST_END;
      for (i = 0; i < tbl_count; i++) begin
         if (!(stop <= 64'(tbl_base[i]) || 64'(base) >= end_of(tbl_base[i], tbl_size[i])))
            return STATUS_OVERLAP;
      end
      tbl_base[tbl_count] = base;
      tbl_size[tbl_count] = pages;
      tbl_used[tbl_count] = '0;
      tbl_count++;
      sum_total = sat_sum(sum_total, pages);
      sum_free  = sat_sum(sum_free, pages);
      return STATUS_OK;
   endfunction

   // first fit in insertion order, bump from the used mark of that region
   function automatic status_type try_alloc(input logic [PAGE_W-1:0] want,
                                            output logic [BASE_W-1:0] addr);
      logic [PAGE_W-1:0] room;
      logic [63:0]       full_addr;
      int                i;
      addr = '0;
      if (want == '0) return STATUS_ZERO;
      for (i = 0; i < tbl_count; i++) begin
         room = tbl_size[i] - tbl_used[i];
         if (want <= room) begin
            full_addr = 64'(tbl_base[i]) + (64'(tbl_used[i]) << PAGE_BYTES_LOG2);
            addr = full_addr[BASE_W-1:0];
            tbl_used[i] = tbl_used[i] + want;
            sum_free = (sum_free > {1'b0, want}) ? sum_free - {1'b0, want} : '0;
            return STATUS_OK;
         end
      end
      return STATUS_NO_ROOM;
   endfunction

   function automatic outcome_type apply_request(input logic [MODE_W-1:0] mode,
                                                 input logic [BASE_W-1:0] base,
                                                 input logic [PAGE_W-1:0] pages);
      outcome_type r;
      logic [BASE_W-1:0] addr;
      r.address = '0;
      r.status  = STATUS_OK;
      case (mode)
         MODE_ADD: begin
            r.status = try_add(base, pages);
         end
         MODE_ALLOC: begin
            r.status  = try_alloc(pages, addr);
            r.address = addr;
         end
         MODE_CLEAR: begin
            tbl_count = 0;
            sum_total = '0;
            sum_free  = '0;
         end
         default: ;
      endcase
      r.total      = sum_total;
      r.pages_left = sum_free;
      return r;
   endfunction

   always @(posedge clock) begin
      outcome_type got;
      outcome_type want;
      if (reset) begin
         awaited_q.delete();
         tbl_count = 0;
         sum_total = '0;
         sum_free  = '0;
         err_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.address    = rsp_tdata[BASE_W-1:0];
            got.status     = status_type'(rsp_tuser);
            got.total      = rsp_tdata[BASE_W +: PAGES_W];
            got.pages_left = rsp_tdata[BASE_W+PAGES_W +: PAGES_W];
            if (awaited_q.size() == 0) begin
               $error("result word with nothing awaited: status %0d", got.status);
               err_count++;
            end else begin
               want = awaited_q.pop_front();
               if (got.address !== want.address) begin
                  $error("alloc_address: expected %h, got %h", want.address, got.address);
                  err_count++;
               end
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  err_count++;
               end
               if (got.total !== want.total) begin
                  $error("total_pages: expected %h, got %h", want.total, got.total);
                  err_count++;
               end
               if (got.pages_left !== want.pages_left) begin
                  $error("pages_left: expected %h, got %h", want.pages_left, got.pages_left);
                  err_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            awaited_q.push_back(apply_request(req_tuser, req_tdata[BASE_W-1:0],
                                              req_tdata[BASE_W +: PAGE_W]));
      end
      mismatches  <= err_count;
      outstanding <= awaited_q.size();
   end

endmodule

FILE: tb/page_region_bump_allocator_tb.sv
`timescale 1ns / 1ps
// testbench top for the page region bump allocator: stimulus, handshakes and verdict
module page_region_bump_allocator_tb;
   import prba_pkg::*;

   // mode three is not decoded by the block, it must come back as a no-op
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   localparam int ITEM_TARGET   = 1550;
   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int PRESSURE_AT   = 150;   // result word count at which the sink holds off
   localparam int PRESSURE_HOLD = 400;   // cycles of that hold-off
   localparam int SETTLE_CYCLES = 200;   // longer than a full 128 region scan
   localparam logic [BASE_W-1:0] TOP_PAGE = 48'hFFFF_FFFF_F000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [MODE_W-1:0]     req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;

   int mismatches;
   int outstanding;
   int cycle_count = 0;
   int items_sent = 0;
   bit sender_quiet = 1'b0;
   bit sink_quiet = 1'b0;

   // page index where the next well-formed region of a phase goes
   logic [PAGE_W:0] layout_page = '0;
   logic [PAGE_W:0] layout_start = '0;

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   page_region_bump_allocator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   prba_checker u_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // watchdog, a hang or a lost result word ends here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic int idle_draw(input bit quiet);
      return quiet ? 0 : int'($urandom_range(0, 12));
   endfunction

   function automatic logic [BASE_W-1:0] rand_base();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[BASE_W-1:0];
   endfunction

   function automatic logic [PAGE_W-1:0] rand_pages();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[PAGE_W-1:0];
   endfunction

   function automatic logic [PAGE_W-1:0] pages_upto(input int limit);
      return PAGE_W'($urandom_range(1, limit));
   endfunction

   // one request word; valid stays high across back-to-back words
   task automatic push_word(input logic [MODE_W-1:0] mode,
                            input logic [BASE_W-1:0] base,
                            input logic [PAGE_W-1:0] pages);
      int gap;
      gap = idle_draw(sender_quiet);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      // region_base in the low bits, page count above, zero fill on top
      req_tdata  <= REQ_DATA_W'({pages, base});
      do @(posedge clock); while (!(req_tvalid && req_tready));
      items_sent++;
   endtask

   // clear, and restart the layout cursor, sometimes right at address zero
   task automatic clear_table();
      logic [63:0] r;
      push_word(MODE_CLEAR, rand_base(), rand_pages());
      r = {$urandom, $urandom};
      layout_page = ($urandom_range(0, 3) == 0) ? '0 : {2'b0, r[PAGE_W-2:0]};
      layout_start = layout_page;
   endtask

   // well-formed add: aligned, past the previous region, often touching it
   task automatic add_next_region(input int scale);
      logic [PAGE_W-1:0] size;
      logic [63:0]       base;
      size = pages_upto(scale);
      base = 64'(layout_page) << 12;
      push_word(MODE_ADD, base[BASE_W-1:0], size);
      layout_page = layout_page + {1'b0, size} +
                    (($urandom_range(0, 1) == 0) ? '0 : (PAGE_W+1)'($urandom_range(1, 4)));
   endtask

   task automatic alloc_some(input int scale);
      if ($urandom_range(0, 7) == 0)
         push_word(MODE_ALLOC, rand_base(), rand_pages());
      else
         push_word(MODE_ALLOC, rand_base(), pages_upto((scale > 1) ? scale / 2 : 1));
   endtask

   // malformed or odd requests, most of them rejected
   task automatic noise_word();
      logic [63:0] b;
      logic [63:0] r;
      case ($urandom_range(0, 5))
         0: push_word(MODE_ADD, rand_base(), rand_pages());
         1: begin
            b = {$urandom, $urandom};
            push_word(MODE_ADD, {b[BASE_W-1:12], 12'h000}, rand_pages());
         end
         2: begin
            // lands inside or at the edge of regions already laid out
            r = 64'(layout_start) + 64'($urandom_range(0, 8));
            b = r << 12;
            push_word(MODE_ADD, b[BASE_W-1:0], pages_upto(8));
         end
         3: push_word(MODE_UNUSED, rand_base(), rand_pages());
         4: push_word(MODE_ALLOC, rand_base(), '0);
         default: push_word(MODE_ADD, rand_base(), '0);
      endcase
   endtask

   // result side: random stalls, quiet stretches and one long hold-off
   initial begin
      int stall;
      int taken;
      taken = 0;
      while (reset) @(posedge clock);
      forever begin
         if (taken % 64 == 0) sink_quiet = ($urandom_range(0, 3) == 0);
         stall = idle_draw(sink_quiet);
         if (taken == PRESSURE_AT) stall = PRESSURE_HOLD;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         taken++;
      end
   end

   initial begin
      int phase;
      int n_regions;
      int n_mixed;
      int scale;
      int i;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part: empty table, zero sizes, bad bases, space edges
      push_word(MODE_ALLOC, '0, 36'd5);                     // no room in an empty table
      push_word(MODE_ALLOC, '0, '0);                        // allocate of zero pages
      push_word(MODE_ADD, 48'h0000_0000_1000, '0);          // zero size region
      push_word(MODE_ADD, 48'h0000_0000_1001, 36'd1);       // misaligned base
      push_word(MODE_ADD, TOP_PAGE, 36'd2);                 // one page past the end
      push_word(MODE_ADD, TOP_PAGE, 36'd1);                 // ends exactly at the top
      push_word(MODE_ADD, '0, 36'hF_FFFF_FFFF);             // region at zero, touching
      push_word(MODE_ALLOC, '0, 36'd1);                     // first fit takes the top page
      push_word(MODE_ALLOC, 48'hFFFF_FFFF_FFFF, 36'd1);     // address zero is a success
      push_word(MODE_ALLOC, '0, 36'hF_FFFF_FFFF);           // one page short
      push_word(MODE_ALLOC, '0, 36'hF_FFFF_FFFE);           // drains the last free pages
      push_word(MODE_ALLOC, '0, 36'd1);                     // nothing left
      push_word(MODE_ADD, 48'h0000_0000_1000, 36'd1);       // overlap
      push_word(MODE_ADD, TOP_PAGE, 36'hF_FFFF_FFFF);       // past end beats overlap
      push_word(MODE_UNUSED, 48'hFFFF_FFFF_FFFF, 36'hF_FFFF_FFFF);
      push_word(MODE_CLEAR, '0, '0);
      push_word(MODE_ADD, '0, 36'd1);
      push_word(MODE_ALLOC, '0, 36'd1);
      push_word(MODE_CLEAR, 48'hFFFF_FFFF_FFFF, 36'hF_FFFF_FFFF);

      // random part: phases of region layout followed by allocations and noise
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         sender_quiet = ($urandom_range(0, 4) == 0);
         if (phase == 0 || $urandom_range(0, 2) != 0 ||
             layout_page > {3'b011, {(PAGE_W-2){1'b0}}})
            clear_table();
         case ($urandom_range(0, 2))
            0: scale = 4;
            1: scale = 256;
            default: scale = 1 << 20;
         endcase
         n_regions = $urandom_range(1, 12);
         // every ninth phase fills the table and keeps adding past full
         if (phase % 9 == 4) begin
            scale = 64;
            n_regions = 131;
         end
         for (i = 0; i < n_regions; i++) begin
            if ($urandom_range(0, 5) == 0)
               if ($urandom_range(0, 1) == 0) alloc_some(scale);
               else noise_word();
            add_next_region(scale);
         end
         n_mixed = $urandom_range(10, 40);
         for (i = 0; i < n_mixed; i++) begin
            if ($urandom_range(0, 9) < 7) alloc_some(scale);
            else noise_word();
         end
         phase++;
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
